@@ rtl/core/hgc_pkg.sv @@
// ----------------------------------------------------------------------------
// hgc_pkg: shared types and codes of the gray histogram unit
// request and response words, request codes, sequencer states
// ----------------------------------------------------------------------------
package hgc_pkg;

  localparam int PIXEL_W = 8;
  localparam int COUNT_W = 23;
  localparam int FRAC_W  = 17;

  typedef enum logic [1:0] {
    REQ_COUNT = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } hgc_req_type_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [PIXEL_W-1:0] pixel;
    logic [PIXEL_W-1:0] bin;
  } hgc_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] cumulative_count;
    logic [FRAC_W-1:0]  bin_fraction;
    logic [FRAC_W-1:0]  cumulative_fraction;
    logic [COUNT_W-1:0] pixel_total;
  } hgc_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_START,
    ST_DIV,
    ST_FIN
  } hgc_state_t;

endpackage

@@ rtl/core/hgc_bin_ram.sv @@
// ----------------------------------------------------------------------------
// hgc_bin_ram: bin counter store
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module hgc_bin_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 23
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/hgc_frac_div.sv @@
// ----------------------------------------------------------------------------
// hgc_frac_div: fixed-point fraction divider
// restoring division, one quotient bit per cycle, clamps to one
// ----------------------------------------------------------------------------
module hgc_frac_div #(
  parameter int CNT_W     = 23,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CNT_W-1:0]   num,
  input  logic [CNT_W-1:0]   den,
  output logic               done,
  output logic [FRAC_BITS:0] quo
);

  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  logic                 busy;
  logic [STEP_W-1:0]    steps;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dvs;
  logic [FRAC_BITS-1:0] q;
  logic                 den_zero;
  logic                 num_ge;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       diff;
  logic                 fits;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      steps    <= STEP_W'(FRAC_BITS);
      dvs      <= den;
      den_zero <= den == '0;
      num_ge   <= num >= den;
      // a quotient of one or more is clamped, keep the remainder bounded
      rem      <= (num >= den) ? '0 : num;
      q        <= '0;
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      rem   <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      q     <= {q[FRAC_BITS-2:0], fits};
    end
  end

  assign quo = den_zero ? '0 :
               num_ge   ? {1'b1, {FRAC_BITS{1'b0}}} :
                          {1'b0, q};

endmodule

@@ rtl/core/gray_histogram_cumulative_unit.sv @@
// ----------------------------------------------------------------------------
// gray_histogram_cumulative_unit: gray-level histogram with cumulative readout
// counts pixels into a bin store, answers bin reads with counts and fractions
// ----------------------------------------------------------------------------
//  channel  | valid / stall         | word
//  ---------+-----------------------+-------------------------------------
//  request  | req_valid / req_stall | hgc_req_t: req_type, pixel, bin
//  response | rsp_valid / rsp_stall | hgc_rsp_t: counts, fractions, total
//
//  a count word is taken every cycle while idle; the store read-modify-write is two
//  stages with forwarding of the last written bin
//  a read walks the store one bin per cycle from bin 0 to the asked bin, then
//  divides one quotient bit per cycle; req_stall stays high until rsp is loaded
//  a clear and reset each run a clearing pass over every bin, req_stall high
//  the response register holds a finished word while new counts are taken
// ----------------------------------------------------------------------------
module gray_histogram_cumulative_unit #(
  parameter int BINS          = 256,
  parameter int MAX_PIXELS    = 4194304,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  hgc_pkg::hgc_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output hgc_pkg::hgc_rsp_t rsp
);

  localparam int AW    = $clog2(BINS);
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int CMP_W = ((AW > hgc_pkg::PIXEL_W) ? AW : hgc_pkg::PIXEL_W) + 1;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PIXELS);
  localparam logic [AW-1:0]    LAST_BIN = AW'(BINS - 1);
  localparam logic [CMP_W-1:0] BINS_CMP = CMP_W'(BINS);

  hgc_pkg::hgc_state_t state;
  hgc_pkg::hgc_state_t state_next;

  logic req_acc;
  logic is_count;
  logic is_read;
  logic is_clear;
  logic pix_ok;
  logic bin_ok;
  logic [AW-1:0] pix_addr;

  // store ports
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [CNT_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] wr_data;

  // count pipeline
  logic             s1_valid;
  logic [AW-1:0]    s1_addr;
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [CNT_W-1:0] fwd_data;
  logic [CNT_W-1:0] cur_val;
  logic [CNT_W-1:0] inc_val;
  logic [CNT_W-1:0] total;

  // clearing pass and bin walk
  logic [AW-1:0]    clr_idx;
  logic [AW-1:0]    walk_idx;
  logic [AW-1:0]    walk_last;
  logic             walk_issuing;
  logic             rd_pending;
  logic [AW-1:0]    rd_idx;
  logic [hgc_pkg::PIXEL_W-1:0] req_bin;
  logic [AW-1:0]    req_bin_addr;
  logic             req_bin_ok;
  logic [CNT_W-1:0] own;
  logic [CNT_W-1:0] acc;
  logic [CNT_W:0]   acc_sum;
  logic [CNT_W-1:0] acc_sat;

  // dividers
  logic                   div_start;
  logic                   own_done;
  logic                   cum_done;
  logic [FRACTION_BITS:0] own_quo;
  logic [FRACTION_BITS:0] cum_quo;
  logic                   rsp_load;

  assign req_acc  = req_valid && !req_stall;
  assign is_count = req_acc && req.req_type == hgc_pkg::REQ_COUNT;
  assign is_read  = req_acc && req.req_type == hgc_pkg::REQ_READ;
  assign is_clear = req_acc && req.req_type == hgc_pkg::REQ_CLEAR;
  assign pix_ok   = CMP_W'(req.pixel) < BINS_CMP;
  assign bin_ok   = CMP_W'(req.bin) < BINS_CMP;
  assign pix_addr = AW'(req.pixel);

  assign rd_en   = (is_count && pix_ok) || (state == hgc_pkg::ST_WALK && walk_issuing);
  assign rd_addr = (state == hgc_pkg::ST_WALK) ? walk_idx : pix_addr;

  // the bin written at the last edge is newer than what the store returned
  assign cur_val = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;
  assign inc_val = (cur_val < MAX_CNT) ? cur_val + CNT_W'(1) : cur_val;

  assign wr_en   = (state == hgc_pkg::ST_CLEAR) || s1_valid;
  assign wr_addr = (state == hgc_pkg::ST_CLEAR) ? clr_idx : s1_addr;
  assign wr_data = (state == hgc_pkg::ST_CLEAR) ? '0 : inc_val;

  assign acc_sum = {1'b0, acc} + {1'b0, rd_data};
  assign acc_sat = (acc_sum > {1'b0, MAX_CNT}) ? MAX_CNT : acc_sum[CNT_W-1:0];

  assign div_start = state == hgc_pkg::ST_START;

  hgc_bin_ram #(
    .DEPTH (BINS),
    .AW    (AW),
    .DW    (CNT_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  hgc_frac_div #(
    .CNT_W     (CNT_W),
    .FRAC_BITS (FRACTION_BITS)
  ) u_div_own (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (own),
    .den   (total),
    .done  (own_done),
    .quo   (own_quo)
  );

  hgc_frac_div #(
    .CNT_W     (CNT_W),
    .FRAC_BITS (FRACTION_BITS)
  ) u_div_cum (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (total),
    .done  (cum_done),
    .quo   (cum_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hgc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_load   = 1'b0;
    case (state)
      hgc_pkg::ST_CLEAR: begin
        if (clr_idx == LAST_BIN) begin
          state_next = hgc_pkg::ST_IDLE;
        end
      end
      hgc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (is_read) begin
          state_next = hgc_pkg::ST_WALK;
        end else if (is_clear) begin
          state_next = hgc_pkg::ST_CLEAR;
        end
      end
      hgc_pkg::ST_WALK: begin
        if (rd_pending && rd_idx == walk_last) begin
          state_next = hgc_pkg::ST_START;
        end
      end
      hgc_pkg::ST_START: begin
        state_next = hgc_pkg::ST_DIV;
      end
      hgc_pkg::ST_DIV: begin
        if (own_done && cum_done) begin
          state_next = hgc_pkg::ST_FIN;
        end
      end
      hgc_pkg::ST_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = hgc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hgc_pkg::ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      total        <= '0;
      s1_valid     <= 1'b0;
      fwd_valid    <= 1'b0;
      walk_issuing <= 1'b0;
      rd_pending   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      s1_valid  <= is_count && pix_ok;
      fwd_valid <= s1_valid;

      if (state == hgc_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (is_clear) begin
        clr_idx <= '0;
        total   <= '0;
      end
      if (is_count && pix_ok && total < MAX_CNT) begin
        total <= total + CNT_W'(1);
      end

      if (is_read) begin
        walk_issuing <= 1'b1;
        rd_pending   <= 1'b0;
      end else if (state == hgc_pkg::ST_WALK) begin
        rd_pending <= walk_issuing;
        if (walk_issuing && walk_idx == walk_last) begin
          walk_issuing <= 1'b0;
        end
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s1_addr  <= pix_addr;
    fwd_addr <= s1_addr;
    fwd_data <= inc_val;

    if (is_read) begin
      walk_idx     <= '0;
      walk_last    <= bin_ok ? AW'(req.bin) : LAST_BIN;
      req_bin      <= req.bin;
      req_bin_addr <= AW'(req.bin);
      req_bin_ok   <= bin_ok;
      own          <= '0;
      acc          <= '0;
    end else if (state == hgc_pkg::ST_WALK) begin
      if (walk_issuing) begin
        rd_idx <= walk_idx;
        if (walk_idx != walk_last) begin
          walk_idx <= walk_idx + AW'(1);
        end
      end
      if (rd_pending) begin
        acc <= acc_sat;
        if (req_bin_ok && rd_idx == req_bin_addr) begin
          own <= rd_data;
        end
      end
    end

    if (rsp_load) begin
      rsp.bin_index           <= req_bin;
      rsp.bin_count           <= hgc_pkg::COUNT_W'(own);
      rsp.cumulative_count    <= hgc_pkg::COUNT_W'(acc);
      rsp.bin_fraction        <= hgc_pkg::FRAC_W'(own_quo);
      rsp.cumulative_fraction <= hgc_pkg::FRAC_W'(cum_quo);
      rsp.pixel_total         <= hgc_pkg::COUNT_W'(total);
    end
  end

endmodule

@@ rtl/core/hgc_checker.sv @@
// ----------------------------------------------------------------------------
// hgc_checker: port-level checks of the gray histogram unit
// response word consistency, clearing pass after reset
// ----------------------------------------------------------------------------
module hgc_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input hgc_pkg::hgc_req_t req,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input hgc_pkg::hgc_rsp_t rsp
);

  // a response word waiting on a stall stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // clearing pass runs right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during clearing pass");

  // a bin never holds more than the running sum up to it, nor the sum more than the total
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.bin_count <= rsp.cumulative_count &&
                  rsp.cumulative_count <= rsp.pixel_total)
    else $error("bin, cumulative and total counts out of order");

  // empty histogram gives zero fractions
  a_empty_frac: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pixel_total == '0 |->
      rsp.bin_fraction == '0 && rsp.cumulative_fraction == '0)
    else $error("nonzero fraction with zero total");

  // fraction of the bin never exceeds the cumulative fraction
  a_frac_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.bin_fraction <= rsp.cumulative_fraction)
    else $error("bin fraction above cumulative fraction");

endmodule

bind gray_histogram_cumulative_unit hgc_checker u_hgc_checker (.*);

@@ tb/gray_histogram_cumulative_unit_tb.sv @@
// ----------------------------------------------------------------------------
// gray_histogram_cumulative_unit_tb: self-checking bench of the histogram unit
// a short script of fixed words with some answers typed in, then random
// count / read / clear traffic; every read answer is compared field by field
// against its typed answer or a software histogram kept beside the block, with random idling on
// both channels
// ----------------------------------------------------------------------------
module gray_histogram_cumulative_unit_tb;

  localparam logic [hgc_pkg::COUNT_W-1:0] PIXEL_CAP   = 23'd4194304;
  localparam logic [hgc_pkg::FRAC_W-1:0]  UNITY       = 17'h10000;
  localparam int                          ITEM_GOAL   = 1300;
  localparam int                          QUIET_TAIL  = 200;
  localparam int                          DRAIN_WAIT  = 320;
  localparam int unsigned                 CYCLE_LIMIT = 2000000;

  typedef struct {
    hgc_pkg::hgc_req_t word;
    bit                known;
    hgc_pkg::hgc_rsp_t answer;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  hgc_pkg::hgc_req_t req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  hgc_pkg::hgc_rsp_t rsp;

  // software copy of the bin store
  logic [hgc_pkg::COUNT_W-1:0] bin_tally [256];
  logic [hgc_pkg::COUNT_W-1:0] pixel_sum;

  hgc_pkg::hgc_rsp_t pending_reads [$];
  script_row_t       script [$];
  hgc_pkg::hgc_rsp_t want_rsp;
  bit                quiet = 1'b0;
  int                hold_cnt = 0;
  int                mismatches = 0;
  int unsigned       cycle_count = 0;
  logic [7:0]        hot_pixels [5] = '{8'd0, 8'd17, 8'd128, 8'd254, 8'd255};

  gray_histogram_cumulative_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic hgc_pkg::hgc_req_t mk_req(hgc_pkg::hgc_req_type_t kind,
                                               logic [7:0] pix, logic [7:0] b);
    hgc_pkg::hgc_req_t w;
    w.req_type = kind;
    w.pixel    = pix;
    w.bin      = b;
    return w;
  endfunction

  function automatic hgc_pkg::hgc_rsp_t mk_rsp(int unsigned idx, int unsigned cnt,
                                               int unsigned cum, int unsigned bf,
                                               int unsigned cf, int unsigned tot);
    hgc_pkg::hgc_rsp_t r;
    r.bin_index           = idx[hgc_pkg::PIXEL_W-1:0];
    r.bin_count           = cnt[hgc_pkg::COUNT_W-1:0];
    r.cumulative_count    = cum[hgc_pkg::COUNT_W-1:0];
    r.bin_fraction        = bf[hgc_pkg::FRAC_W-1:0];
    r.cumulative_fraction = cf[hgc_pkg::FRAC_W-1:0];
    r.pixel_total         = tot[hgc_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic script_row(hgc_pkg::hgc_req_t w, bit known, hgc_pkg::hgc_rsp_t answer);
    script_row_t row;
    row.word   = w;
    row.known  = known;
    row.answer = answer;
    script.push_back(row);
  endtask

  // count over total as unsigned q1.16, floor, clamped at one
  function automatic logic [hgc_pkg::FRAC_W-1:0] q16_ratio(
      logic [hgc_pkg::COUNT_W-1:0] num, logic [hgc_pkg::COUNT_W-1:0] den);
    logic [38:0] q;
    if (den == '0) return '0;
    if (num >= den) return UNITY;
    q = {num, 16'd0} / {16'd0, den};
    return (q > {22'd0, UNITY}) ? UNITY : q[hgc_pkg::FRAC_W-1:0];
  endfunction

  task automatic histogram_predict(input hgc_pkg::hgc_req_t w, output bit gives,
                                   output hgc_pkg::hgc_rsp_t r);
    logic [hgc_pkg::COUNT_W:0] running;
    gives = 1'b0;
    r = '0;
    running = '0;
    case (w.req_type)
      hgc_pkg::REQ_COUNT: begin
        // every 8-bit pixel lands in one of the 256 bins
        if (bin_tally[w.pixel] < PIXEL_CAP) bin_tally[w.pixel] = bin_tally[w.pixel] + 23'd1;
        if (pixel_sum < PIXEL_CAP) pixel_sum = pixel_sum + 23'd1;
      end
      hgc_pkg::REQ_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        pixel_sum = '0;
      end
      hgc_pkg::REQ_READ: begin
        for (int i = 0; i <= int'(w.bin); i++) begin
          running = running + {1'b0, bin_tally[i]};
          if (running > {1'b0, PIXEL_CAP}) running = {1'b0, PIXEL_CAP};
        end
        gives                 = 1'b1;
        r.bin_index           = w.bin;
        r.bin_count           = bin_tally[w.bin];
        r.cumulative_count    = running[hgc_pkg::COUNT_W-1:0];
        r.bin_fraction        = q16_ratio(bin_tally[w.bin], pixel_sum);
        r.cumulative_fraction = q16_ratio(running[hgc_pkg::COUNT_W-1:0], pixel_sum);
        r.pixel_total         = pixel_sum;
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // drive one word, wait for it to be taken, then update the software histogram
  task automatic send_word(hgc_pkg::hgc_req_t w, bit known, hgc_pkg::hgc_rsp_t answer);
    bit                gives;
    hgc_pkg::hgc_rsp_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    histogram_predict(w, gives, r);
    if (gives) pending_reads.push_back(known ? answer : r);
  endtask

  // response side stalls in short bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (hold_cnt == 0 && $urandom_range(0, 7) == 0) hold_cnt = int'($urandom_range(1, 5));
      if (hold_cnt != 0) begin
        rsp_stall <= 1'b1;
        hold_cnt--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_reads.size() == 0) begin
        note_mismatch("response word with no read pending, bin_index", 32'(rsp.bin_index), 0);
      end else begin
        want_rsp = pending_reads.pop_front();
        if (rsp.bin_index !== want_rsp.bin_index)
          note_mismatch("bin_index", 32'(rsp.bin_index), 32'(want_rsp.bin_index));
        if (rsp.bin_count !== want_rsp.bin_count)
          note_mismatch("bin_count", 32'(rsp.bin_count), 32'(want_rsp.bin_count));
        if (rsp.cumulative_count !== want_rsp.cumulative_count)
          note_mismatch("cumulative_count", 32'(rsp.cumulative_count),
                        32'(want_rsp.cumulative_count));
        if (rsp.bin_fraction !== want_rsp.bin_fraction)
          note_mismatch("bin_fraction", 32'(rsp.bin_fraction), 32'(want_rsp.bin_fraction));
        if (rsp.cumulative_fraction !== want_rsp.cumulative_fraction)
          note_mismatch("cumulative_fraction", 32'(rsp.cumulative_fraction),
                        32'(want_rsp.cumulative_fraction));
        if (rsp.pixel_total !== want_rsp.pixel_total)
          note_mismatch("pixel_total", 32'(rsp.pixel_total), 32'(want_rsp.pixel_total));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gray_histogram_cumulative_unit_tb failed");
      $finish;
    end
  end

  initial begin
    int                useful;
    int                pick;
    hgc_pkg::hgc_req_t w;
    hgc_pkg::hgc_rsp_t none_rsp;

    useful   = 0;
    none_rsp = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    pixel_sum = '0;

    // empty store, extremes of the bin range, unused code, small known histograms
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'd0), 1'b1, mk_rsp(0, 0, 0, 0, 0, 0));
    script_row(mk_req(hgc_pkg::REQ_READ, 8'hff, 8'd255), 1'b1, mk_rsp(255, 0, 0, 0, 0, 0));
    script_row(mk_req(hgc_pkg::REQ_NONE, 8'hff, 8'hff), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_COUNT, 8'd0, 8'hff), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_COUNT, 8'd255, 8'h00), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_COUNT, 8'd0, 8'h00), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'd0), 1'b1,
               mk_rsp(0, 2, 2, 43690, 43690, 3));
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'd255), 1'b1,
               mk_rsp(255, 1, 3, 21845, 65536, 3));
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'd128), 1'b1,
               mk_rsp(128, 0, 2, 0, 43690, 3));
    script_row(mk_req(hgc_pkg::REQ_COUNT, 8'haa, 8'h55), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_COUNT, 8'h55, 8'haa), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_COUNT, 8'haa, 8'h00), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h55, 8'haa), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_READ, 8'haa, 8'h55), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'h54), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_NONE, 8'h00, 8'h00), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_CLEAR, 8'hff, 8'hff), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'd255), 1'b1, mk_rsp(255, 0, 0, 0, 0, 0));
    script_row(mk_req(hgc_pkg::REQ_COUNT, 8'd1, 8'h00), 1'b0, none_rsp);
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'd0), 1'b1, mk_rsp(0, 0, 0, 0, 0, 1));
    script_row(mk_req(hgc_pkg::REQ_READ, 8'h00, 8'd1), 1'b1,
               mk_rsp(1, 1, 1, 65536, 65536, 1));
    script_row(mk_req(hgc_pkg::REQ_CLEAR, 8'h00, 8'h00), 1'b0, none_rsp);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_word(script[i].word, script[i].known, script[i].answer);

    while (useful < ITEM_GOAL) begin
      // hold off until every read answer is back
      if (useful % 350 == 175) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0) @(posedge clk);
      end
      if (useful >= ITEM_GOAL - QUIET_TAIL) quiet = 1'b1;
      w.req_type = hgc_pkg::REQ_COUNT;
      w.pixel    = 8'($urandom_range(0, 255));
      w.bin      = 8'($urandom_range(0, 255));
      pick       = int'($urandom_range(0, 99));
      if (pick < 72) begin
        if ($urandom_range(0, 1) == 0) w.pixel = hot_pixels[$urandom_range(0, 4)];
      end else if (pick < 92) begin
        w.req_type = hgc_pkg::REQ_READ;
        if ($urandom_range(0, 1) == 0) w.bin = hot_pixels[$urandom_range(0, 4)];
      end else if (pick < 94) begin
        w.req_type = hgc_pkg::REQ_CLEAR;
      end else begin
        w.req_type = hgc_pkg::REQ_NONE;
      end
      send_word(w, 1'b0, none_rsp);
      if (w.req_type != hgc_pkg::REQ_NONE) useful++;
    end

    req_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    // a clear may still be in flight
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("gray_histogram_cumulative_unit_tb passed");
    end else begin
      $display("gray_histogram_cumulative_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ gray_histogram_cumulative_unit.f @@
rtl/core/hgc_pkg.sv
rtl/core/hgc_bin_ram.sv
rtl/core/hgc_frac_div.sv
rtl/core/gray_histogram_cumulative_unit.sv
rtl/core/hgc_checker.sv
tb/gray_histogram_cumulative_unit_tb.sv
